>>> hdl/mini_risc_execute_step_core_macros.svh
// Assertion macros used by the checker file of the execute step core
`ifndef MINI_RISC_EXECUTE_STEP_CORE_MACROS_SVH
`define MINI_RISC_EXECUTE_STEP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MRX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MRX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

>>> hdl/mrx_pkg.sv
// Shared constants, opcodes and interface structs of the execute step core
package mrx_pkg;

    localparam int DATA_W    = 32;
    localparam int PC_W      = 14;
    localparam int PW_W      = PC_W + 1;
    localparam int NUM_REGS  = 16;
    localparam int REG_AW    = $clog2(NUM_REGS);
    // Data memory depth; a power of two, so an address wraps by keeping low bits
    localparam int MEM_WORDS = 16384;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_SLT  = 4'd2,
        OP_OR   = 4'd3,
        OP_NAND = 4'd4,
        OP_ADDI = 4'd5,
        OP_SLTI = 4'd6,
        OP_ORI  = 4'd7,
        OP_LUI  = 4'd8,
        OP_LW   = 4'd9,
        OP_SW   = 4'd10,
        OP_BEQ  = 4'd11,
        OP_JALR = 4'd12,
        OP_J    = 4'd13,
        OP_HALT = 4'd14,
        OP_DATA = 4'd15
    } opcode_t;

    // Execute slot phases: PH_EXEC executes a word, PH_LOAD waits for the memory data of a load
    typedef enum logic {
        PH_EXEC,
        PH_LOAD
    } phase_t;

    // Register file write port
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    // Outcome of one executed word
    typedef struct packed {
        logic [DATA_W-1:0] next_pc;
        logic              reg_we;
        logic [REG_AW-1:0] reg_addr;
        logic [DATA_W-1:0] reg_val;
        logic              mem_we;
        logic              mem_re;
        logic [MEM_AW-1:0] mem_addr;
        logic [DATA_W-1:0] mem_data;
        logic              halted;
    } exec_res_t;

endpackage

>>> hdl/mrx_ram.sv
// Generic single-write, single-read RAM with registered read data
module mrx_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and read old contents on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/mrx_regfile.sv
// Register file: two RAM copies for two reads, reset valid bits and write bypass
module mrx_regfile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [mrx_pkg::REG_AW-1:0]    rd_addr_a,
    input  logic [mrx_pkg::REG_AW-1:0]    rd_addr_b,
    input  mrx_pkg::rf_wr_t               wr,
    output logic [mrx_pkg::DATA_W-1:0]    rd_data_a,
    output logic [mrx_pkg::DATA_W-1:0]    rd_data_b
);
    import mrx_pkg::*;

    logic [NUM_REGS-1:0] valid_reg;
    logic                hit_a_reg;
    logic                hit_b_reg;
    logic                live_a_reg;
    logic                live_b_reg;
    logic [DATA_W-1:0]   byp_data_reg;
    logic [DATA_W-1:0]   ram_a;
    logic [DATA_W-1:0]   ram_b;

    mrx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (ram_a)
    );

    mrx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (ram_b)
    );

    // Mark entries written since reset; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Capture same-edge write hits and valid bits with each read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_a_reg  <= 1'b0;
            hit_b_reg  <= 1'b0;
            live_a_reg <= 1'b0;
            live_b_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_a_reg  <= wr.en && (wr.addr == rd_addr_a);
            hit_b_reg  <= wr.en && (wr.addr == rd_addr_b);
            live_a_reg <= valid_reg[rd_addr_a];
            live_b_reg <= valid_reg[rd_addr_b];
        end
    end

    // Hold the bypass data of the write that collided with the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr.data;
        end
    end

    // Select bypass, RAM data or zero
    always_comb
    begin
        if (hit_a_reg)
        begin
            rd_data_a = byp_data_reg;
        end
        else if (live_a_reg)
        begin
            rd_data_a = ram_a;
        end
        else
        begin
            rd_data_a = '0;
        end

        if (hit_b_reg)
        begin
            rd_data_b = byp_data_reg;
        end
        else if (live_b_reg)
        begin
            rd_data_b = ram_b;
        end
        else
        begin
            rd_data_b = '0;
        end
    end

endmodule

>>> hdl/mrx_exec.sv
// Execute logic: ALU, branch and jump targets, write and memory decisions
module mrx_exec (
    input  mrx_pkg::opcode_t              op,
    input  logic [mrx_pkg::PC_W-1:0]      pc,
    input  logic [mrx_pkg::REG_AW-1:0]    rt,
    input  logic [mrx_pkg::REG_AW-1:0]    rd,
    input  logic [mrx_pkg::DATA_W-1:0]    imm,
    input  logic [mrx_pkg::DATA_W-1:0]    a,
    input  logic [mrx_pkg::DATA_W-1:0]    b,
    input  logic [mrx_pkg::PW_W-1:0]      prog_words,
    output mrx_pkg::exec_res_t            res
);
    import mrx_pkg::*;

    logic [DATA_W-1:0] pc_ext;
    logic [DATA_W-1:0] pc_plus1;
    logic [DATA_W-1:0] srcb;
    logic [DATA_W-1:0] sum;
    logic              end_of_prog;
    logic              use_imm;

    assign pc_ext      = DATA_W'(pc);
    assign pc_plus1    = pc_ext + DATA_W'(1);
    assign end_of_prog = PW_W'(pc) >= prog_words;
    assign use_imm     = (op == OP_ADDI) || (op == OP_SLTI) || (op == OP_ORI) ||
                         (op == OP_LUI) || (op == OP_LW) || (op == OP_SW);
    assign srcb        = use_imm ? imm : b;
    assign sum         = a + srcb;

    // Decode and compute the outcome of one word
    always_comb
    begin
        res         = '0;
        res.next_pc = pc_plus1;
        if (end_of_prog || (op == OP_HALT))
        begin
            res.halted  = 1'b1;
            res.next_pc = pc_ext;
        end
        else if (op == OP_DATA)
        begin
            res.mem_we   = 1'b1;
            res.mem_addr = pc_ext[MEM_AW-1:0];
            res.mem_data = imm;
        end
        else
        begin
            case (op)
                OP_ADD, OP_ADDI:
                begin
                    res.reg_we  = 1'b1;
                    res.reg_val = sum;
                end
                OP_SUB:
                begin
                    res.reg_we  = 1'b1;
                    res.reg_val = a - srcb;
                end
                OP_SLT, OP_SLTI:
                begin
                    res.reg_we  = 1'b1;
                    res.reg_val = DATA_W'($signed(a) < $signed(srcb));
                end
                OP_OR, OP_ORI:
                begin
                    res.reg_we  = 1'b1;
                    res.reg_val = a | srcb;
                end
                OP_NAND:
                begin
                    res.reg_we  = 1'b1;
                    res.reg_val = ~(a & srcb);
                end
                OP_LUI:
                begin
                    res.reg_we  = 1'b1;
                    res.reg_val = {srcb[DATA_W-17:0], 16'h0000};
                end
                OP_LW:
                begin
                    res.reg_we   = 1'b1;
                    res.mem_re   = 1'b1;
                    res.mem_addr = sum[MEM_AW-1:0];
                end
                OP_SW:
                begin
                    res.mem_we   = 1'b1;
                    res.mem_addr = sum[MEM_AW-1:0];
                    res.mem_data = b;
                end
                OP_BEQ:
                begin
                    if (a == b)
                    begin
                        res.next_pc = pc_plus1 + imm;
                    end
                end
                OP_JALR:
                begin
                    res.reg_we  = 1'b1;
                    res.reg_val = pc_plus1;
                    res.next_pc = a;
                end
                OP_J:
                begin
                    res.next_pc = imm;
                end
                default:
                begin
                end
            endcase
            if (res.reg_we)
            begin
                res.reg_addr = (op == OP_ADD || op == OP_SUB || op == OP_SLT ||
                                op == OP_OR || op == OP_NAND) ? rd : rt;
            end
        end
    end

endmodule

>>> hdl/mini_risc_execute_step_core.sv
// Top level of the execute step core: issue slot, execute slot, data memory, output register
//
//  channel   direction  handshake                 payload
//  cfg       in         cfg_wr_en                 cfg_wr_data (program_words)
//  in        in         in_valid / in_stall       opcode pc src_reg second_reg dest_reg immediate
//  out       out        out_valid / out_stall     next_pc reg_written written_reg written_value
//                                                 mem_written halted
//
//  The accept edge reads the register file RAMs and loads the execute slot, which then executes
//  and loads the output register. One word per cycle is sustained while no lw or out_stall
//  holds the flow; lw adds a PH_LOAD phase for the registered read port of the data memory.
//  Reset clears control and the register file valid bits at once; no clearing pass.
//  out_stall holds the output register and backs up into in_stall.
module mini_risc_execute_step_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mrx_pkg::PW_W-1:0]            cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [3:0]                          opcode,
    input  logic [mrx_pkg::PC_W-1:0]            pc,
    input  logic [mrx_pkg::REG_AW-1:0]          src_reg,
    input  logic [mrx_pkg::REG_AW-1:0]          second_reg,
    input  logic [mrx_pkg::REG_AW-1:0]          dest_reg,
    input  logic signed [mrx_pkg::DATA_W-1:0]   immediate,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mrx_pkg::DATA_W-1:0]   next_pc,
    output logic                                reg_written,
    output logic [mrx_pkg::REG_AW-1:0]          written_reg,
    output logic signed [mrx_pkg::DATA_W-1:0]   written_value,
    output logic                                mem_written,
    output logic                                halted
);
    import mrx_pkg::*;

    logic [PW_W-1:0]   prog_words_reg;
    logic              accept;

    // Execute slot
    logic              s1_valid_reg;
    logic              s1_valid_next;
    opcode_t           s1_op_reg;
    logic [PC_W-1:0]   s1_pc_reg;
    logic [REG_AW-1:0] s1_rt_reg;
    logic [REG_AW-1:0] s1_rd_reg;
    logic [DATA_W-1:0] s1_imm_reg;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic              s1_done;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic [DATA_W-1:0] out_next_pc_reg;
    logic              out_reg_we_reg;
    logic [REG_AW-1:0] out_reg_addr_reg;
    logic [DATA_W-1:0] out_reg_val_reg;
    logic              out_mem_we_reg;
    logic              out_halted_reg;

    logic [DATA_W-1:0] rf_a;
    logic [DATA_W-1:0] rf_b;
    rf_wr_t            rf_wr;
    exec_res_t         ex;
    logic              dmem_rd_en;
    logic [DATA_W-1:0] dmem_rd_data;
    logic [DATA_W-1:0] wb_val;

    // Program length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_words_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            prog_words_reg <= cfg_wr_data;
        end
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !s1_done;
    assign out_free = !out_valid_reg || !out_stall;

    mrx_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (src_reg),
        .rd_addr_b (second_reg),
        .wr        (rf_wr),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    mrx_exec u_exec (
        .op         (s1_op_reg),
        .pc         (s1_pc_reg),
        .rt         (s1_rt_reg),
        .rd         (s1_rd_reg),
        .imm        (s1_imm_reg),
        .a          (rf_a),
        .b          (rf_b),
        .prog_words (prog_words_reg),
        .res        (ex)
    );

    mrx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk     (clk),
        .wr_en   (s1_done && ex.mem_we),
        .wr_addr (ex.mem_addr),
        .wr_data (ex.mem_data),
        .rd_en   (dmem_rd_en),
        .rd_addr (ex.mem_addr),
        .rd_data (dmem_rd_data)
    );

    // Write back on completion; a load takes the memory data
    assign wb_val     = ex.mem_re ? dmem_rd_data : ex.reg_val;
    assign rf_wr.en   = s1_done && ex.reg_we;
    assign rf_wr.addr = ex.reg_addr;
    assign rf_wr.data = wb_val;

    // Execute slot sequencing: issue the load read, then complete
    always_comb
    begin
        phase_next = phase_reg;
        s1_done    = 1'b0;
        dmem_rd_en = 1'b0;
        case (phase_reg)
            PH_EXEC:
            begin
                if (s1_valid_reg && ex.mem_re)
                begin
                    dmem_rd_en = 1'b1;
                    phase_next = PH_LOAD;
                end
                else if (s1_valid_reg && out_free)
                begin
                    s1_done = 1'b1;
                end
            end
            PH_LOAD:
            begin
                if (out_free)
                begin
                    s1_done    = 1'b1;
                    phase_next = PH_EXEC;
                end
            end
            default:
            begin
                phase_next = PH_EXEC;
            end
        endcase
    end

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_done);
    assign out_valid_next = s1_done || (out_valid_reg && out_stall);

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_EXEC;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the execute slot on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= opcode_t'(opcode);
            s1_pc_reg  <= pc;
            s1_rt_reg  <= second_reg;
            s1_rd_reg  <= dest_reg;
            s1_imm_reg <= immediate;
        end
    end

    // Load the output register on completion, hold it while stalled
    always_ff @(posedge clk)
    begin
        if (s1_done)
        begin
            out_next_pc_reg  <= ex.next_pc;
            out_reg_we_reg   <= ex.reg_we;
            out_reg_addr_reg <= ex.reg_addr;
            out_reg_val_reg  <= wb_val;
            out_mem_we_reg   <= ex.mem_we;
            out_halted_reg   <= ex.halted;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_pc       = out_next_pc_reg;
    assign reg_written   = out_reg_we_reg;
    assign written_reg   = out_reg_addr_reg;
    assign written_value = out_reg_val_reg;
    assign mem_written   = out_mem_we_reg;
    assign halted        = out_halted_reg;

endmodule

>>> hdl/mrx_checker.sv
// Port-level checker of the execute step core and its bind
`include "mini_risc_execute_step_core_macros.svh"

module mrx_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [mrx_pkg::DATA_W-1:0]  next_pc,
    input logic                               reg_written,
    input logic [mrx_pkg::REG_AW-1:0]         written_reg,
    input logic signed [mrx_pkg::DATA_W-1:0]  written_value,
    input logic                               mem_written,
    input logic                               halted
);

    // A halted transaction changes no state
    `MRX_ASSERT_NOW(a_halt_no_write, out_valid && halted, !reg_written && !mem_written)

    // No register write reports register and value as zero
    `MRX_ASSERT_NOW(a_no_write_zero, out_valid && !reg_written,
                    (written_reg == '0) && (written_value == '0))

    // One word never writes both register file and memory
    `MRX_ASSERT_NOW(a_one_target, out_valid, !(reg_written && mem_written))

    // Hold a stalled result
    `MRX_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(next_pc) && $stable(written_value))

endmodule

bind mini_risc_execute_step_core mrx_checker u_mrx_checker (.*);
